// ----- hw/rtl/ksw_pkg.sv -----
// Shared types and constants for the key subset shuffle and whitening core.
`timescale 1ns / 1ps
`default_nettype none
package ksw_pkg;

  // Key and round widths for the two variants
  localparam int KEY_LARGE   = 512;
  localparam int KEY_SMALL   = 256;
  localparam int ROUND_LARGE = 56;
  localparam int ROUND_SMALL = 60;

  // Index table geometry
  localparam int TABLE_DEPTH = 512;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int KEY_W       = IDX_W + 1;     // holds a key width up to TABLE_DEPTH
  localparam int POS_W       = 6;
  localparam int ROUND_W     = POS_W + 1;     // holds a round width up to 64
  localparam int BYTE_W      = 8;
  localparam int NIB_W       = 4;
  localparam int WORD_W      = 32;
  localparam int ACC_W       = WORD_W - BYTE_W;
  localparam int SHIFT_W     = $clog2(KEY_W);

  // Command queue between front and back
  localparam int CMDQ_DEPTH  = 4;

  // Input operation codes
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Result kinds
  localparam logic KIND_INDEX = 1'b0;
  localparam logic KIND_WHITE = 1'b1;

  // Variant select
  localparam logic MODE_LARGE = 1'b0;

  typedef enum logic [1:0] {
    CMD_SWAP,
    CMD_WHITE,
    CMD_CLEAR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t             op;
    logic [POS_W-1:0]    pos;
    logic [IDX_W-1:0]    draw;
    logic [NIB_W-1:0]    nibble;
    logic                last;
  } cmd_t;

  typedef struct packed {
    logic                kind;
    logic [POS_W-1:0]    position;
    logic [IDX_W-1:0]    value;
    logic                last;
  } res_t;

  typedef enum logic {
    BK_CLEAR,
    BK_RUN
  } back_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ksw_ram.sv -----
// Generic single-write, dual-read RAM with registered read data (read-first).
`timescale 1ns / 1ps
`default_nettype none
module ksw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered reads; a read of the address being written returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ksw_cmd_fifo.sv -----
// Short command queue that decouples the front from the back.
`timescale 1ns / 1ps
`default_nettype none
module ksw_cmd_fifo
  import ksw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_data,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output cmd_t      head
);

  localparam int AW = $clog2(CMDQ_DEPTH);
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          mem [CMDQ_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(CMDQ_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ksw_front.sv -----
// Front: accepts bytes, packs draw words, tracks round position and phase.
`timescale 1ns / 1ps
`default_nettype none
module ksw_front
  import ksw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic              cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              operation,
  input  wire logic [BYTE_W-1:0] random_byte,
  input  wire logic              q_full,
  output logic                   q_push,
  output cmd_t                   q_data
);

  logic              variant_mode;
  logic [POS_W-1:0]  round_position;
  logic              whitening_phase;
  logic [1:0]        byte_count;
  logic [ACC_W-1:0]  word_accumulator;

  logic [POS_W-1:0]  round_position_next;
  logic              whitening_phase_next;
  logic [1:0]        byte_count_next;
  logic [ACC_W-1:0]  word_accumulator_next;

  logic              accept;
  logic [KEY_W-1:0]  keyw;
  logic [ROUND_W-1:0] roundw;
  logic [KEY_W-1:0]  pos_ext;
  logic [KEY_W-1:0]  span;
  logic [SHIFT_W-1:0] lead;
  logic [WORD_W-1:0] word;
  logic [IDX_W-1:0]  top_bits;
  logic [IDX_W-1:0]  offset;
  logic [IDX_W-1:0]  draw;
  logic              phase_end;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Variant register
  always_ff @(posedge clk) begin
    if (rst) begin
      variant_mode <= MODE_LARGE;
    end else if (cfg_write) begin
      variant_mode <= cfg_data;
    end
  end

  // Draw: position plus the top lead bits of the packed word
  always_comb begin
    keyw    = (variant_mode == MODE_LARGE) ? KEY_W'(KEY_LARGE) : KEY_W'(KEY_SMALL);
    roundw  = (variant_mode == MODE_LARGE) ? ROUND_W'(ROUND_LARGE) : ROUND_W'(ROUND_SMALL);
    pos_ext = KEY_W'(round_position);
    span    = keyw - pos_ext;
    lead    = '0;
    if (keyw > pos_ext) begin
      for (int i = 1; i < KEY_W; i++) begin
        if (span[i]) begin
          lead = SHIFT_W'(i);
        end
      end
    end
    word      = {random_byte, word_accumulator};
    top_bits  = word[WORD_W-1 -: IDX_W];
    offset    = top_bits >> (SHIFT_W'(IDX_W) - lead);
    draw      = IDX_W'(round_position) + offset;
    phase_end = (ROUND_W'(round_position) + ROUND_W'(1)) >= roundw;
  end

  // Next state and command to the back
  always_comb begin
    round_position_next   = round_position;
    whitening_phase_next  = whitening_phase;
    byte_count_next       = byte_count;
    word_accumulator_next = word_accumulator;
    q_push                = 1'b0;
    q_data.op             = CMD_WHITE;
    q_data.pos            = round_position;
    q_data.draw           = draw;
    q_data.nibble         = random_byte[NIB_W-1:0];
    q_data.last           = phase_end;
    if (accept) begin
      if (operation == OP_RESTART) begin
        round_position_next   = '0;
        whitening_phase_next  = 1'b0;
        byte_count_next       = '0;
        word_accumulator_next = '0;
        q_push                = 1'b1;
        q_data.op             = CMD_CLEAR;
      end else if (!whitening_phase) begin
        if (byte_count != 2'd3) begin
          // partial word: collect the byte little-endian
          word_accumulator_next = word_accumulator |
                                  (ACC_W'(random_byte) << (byte_count * 8));
          byte_count_next       = byte_count + 2'd1;
        end else begin
          byte_count_next       = '0;
          word_accumulator_next = '0;
          q_push                = 1'b1;
          q_data.op             = CMD_SWAP;
          q_data.last           = 1'b0;
          if (phase_end) begin
            whitening_phase_next = 1'b1;
            round_position_next  = '0;
          end else begin
            round_position_next  = round_position + POS_W'(1);
          end
        end
      end else begin
        q_push = 1'b1;
        if (phase_end) begin
          whitening_phase_next = 1'b0;
          round_position_next  = '0;
        end else begin
          round_position_next  = round_position + POS_W'(1);
        end
      end
    end
  end

  // Front state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      round_position   <= '0;
      whitening_phase  <= 1'b0;
      byte_count       <= '0;
      word_accumulator <= '0;
    end else begin
      round_position   <= round_position_next;
      whitening_phase  <= whitening_phase_next;
      byte_count       <= byte_count_next;
      word_accumulator <= word_accumulator_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ksw_back.sv -----
// Back: index table swaps, table clearing sweep and the output buffer.
`timescale 1ns / 1ps
`default_nettype none
module ksw_back
  import ksw_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_empty,
  input  cmd_t                 q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output res_t                 out_res
);

  back_state_t      state;
  back_state_t      state_next;
  logic [IDX_W-1:0] clr_idx;

  // Data stage (RAM read data valid)
  logic             d_valid;
  cmd_t             d_cmd;
  logic             fwd_a;
  logic             fwd_b;
  logic [IDX_W-1:0] fwd_data;

  // Second write stage
  logic             w2_valid;
  logic [IDX_W-1:0] w2_addr;
  logic [IDX_W-1:0] w2_data;

  // Output buffer, two entries
  res_t             out_mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       out_count;

  logic             issue;
  logic             start_clear;
  logic             can_emit;
  logic             out_pop;
  logic             d_swap;
  logic [IDX_W-1:0] rd_a;
  logic [IDX_W-1:0] rd_b;
  logic [IDX_W-1:0] val_a;
  logic [IDX_W-1:0] val_b;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] wdata;
  res_t             d_res;

  assign d_swap   = d_valid && (d_cmd.op == CMD_SWAP);
  assign out_pop  = out_valid && !out_stall;
  assign can_emit = ({1'b0, out_count} + {2'b0, d_valid}) < (3'd2 + {2'b0, out_pop});

  ksw_ram #(
    .WIDTH (IDX_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (IDX_W'(q_head.pos)),
    .raddr_b (q_head.draw),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Sequencer: next state and issue decision
  always_comb begin
    state_next  = state;
    issue       = 1'b0;
    start_clear = 1'b0;
    case (state)
      BK_CLEAR: begin
        if (clr_idx == IDX_W'(TABLE_DEPTH - 1)) begin
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (!q_empty) begin
          case (q_head.op)
            CMD_SWAP:  issue = can_emit && !d_swap;
            CMD_WHITE: issue = can_emit;
            CMD_CLEAR: begin
              start_clear = !d_valid && !w2_valid;
              if (start_clear) begin
                state_next = BK_CLEAR;
              end
            end
            default:   issue = 1'b0;
          endcase
        end
      end
      default: state_next = BK_CLEAR;
    endcase
    q_pop = issue || start_clear;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clearing sweep address
  always_ff @(posedge clk) begin
    if (rst || start_clear) begin
      clr_idx <= '0;
    end else if (state == BK_CLEAR) begin
      clr_idx <= clr_idx + IDX_W'(1);
    end
  end

  // Table values with bypass of the write that coincides with the read
  assign val_a = fwd_a ? fwd_data : rd_a;
  assign val_b = fwd_b ? fwd_data : rd_b;

  // Write port: sweep, first swap write, second swap write
  always_comb begin
    we    = 1'b0;
    waddr = clr_idx;
    wdata = clr_idx;
    if (state == BK_CLEAR) begin
      we = 1'b1;
    end else if (d_swap) begin
      we    = 1'b1;
      waddr = IDX_W'(d_cmd.pos);
      wdata = val_b;
    end else if (w2_valid) begin
      we    = 1'b1;
      waddr = w2_addr;
      wdata = w2_data;
    end
  end

  // Data and second write stages
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid  <= 1'b0;
      w2_valid <= 1'b0;
    end else begin
      d_valid  <= issue;
      w2_valid <= d_swap;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      d_cmd    <= q_head;
      fwd_a    <= w2_valid && (w2_addr == IDX_W'(q_head.pos));
      fwd_b    <= w2_valid && (w2_addr == q_head.draw);
      fwd_data <= w2_data;
    end
    if (d_swap) begin
      w2_addr <= d_cmd.draw;
      w2_data <= val_a;
    end
  end

  // Result built in the data stage
  always_comb begin
    d_res.position = d_cmd.pos;
    if (d_cmd.op == CMD_SWAP) begin
      d_res.kind  = KIND_INDEX;
      d_res.value = val_b;
      d_res.last  = 1'b0;
    end else begin
      d_res.kind  = KIND_WHITE;
      d_res.value = IDX_W'(d_cmd.nibble);
      d_res.last  = d_cmd.last;
    end
  end

  // Output buffer
  assign out_valid = (out_count != 2'd0);
  assign out_res   = out_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (d_valid) begin
      out_mem[wr_ptr] <= d_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      out_count <= '0;
    end else begin
      if (d_valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (out_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({d_valid, out_pop})
        2'b10:   out_count <= out_count + 2'd1;
        2'b01:   out_count <= out_count - 2'd1;
        default: out_count <= out_count;
      endcase
    end
  end

  // Checks
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(d_swap && w2_valid))
    else $error("swap write stages collide on the table write port");

  a_out_bound: assert property (@(posedge clk) disable iff (rst)
    out_count <= 2'd2)
    else $error("output buffer overflow");

  a_no_issue_clear: assert property (@(posedge clk) disable iff (rst)
    (state == BK_CLEAR) |-> !issue && !we == 1'b0)
    else $error("command issued during table sweep");

  a_second_write: assert property (@(posedge clk) disable iff (rst)
    d_swap |=> w2_valid && !d_valid == !d_valid)
    else $error("second swap write missing");

  a_clear_drained: assert property (@(posedge clk) disable iff (rst)
    start_clear |=> (state == BK_CLEAR) && !d_valid && !w2_valid)
    else $error("sweep started with a swap in flight");

endmodule
`default_nettype wire

// ----- hw/rtl/key_subset_shuffle_whitening_core.sv -----
// Top level of the key subset shuffle and whitening core.
//
// Usage: the input channel (in_valid / in_stall) carries one transaction per
// random byte, or a restart (operation = 1). Every fourth byte of the shuffle
// phase swaps two index table entries and yields the new key index; in the
// whitening phase every byte yields a nibble, the last one flagged by last.
// The output channel (out_valid / out_stall) carries kind, position, value
// and last. variant_mode is written through cfg_write / cfg_data only while
// idle, the user's rule, not enforced by the block. Results pass the command
// queue, data stage and output buffer. Throughput: one byte per cycle while
// in_stall is low; a swap does not issue while the last one is in the data
// stage (one table write port). Reset and every restart sweep all 512 entries
// to identity, one entry a cycle; items still enter the 4-entry command
// queue and in_stall rises once it fills. A stalled receiver holds results
// in a 2-entry output buffer; the back then stops and the queue backs up.
`timescale 1ns / 1ps
`default_nettype none
module key_subset_shuffle_whitening_core
  import ksw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic              cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              operation,
  input  wire logic [BYTE_W-1:0] random_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   kind,
  output logic [POS_W-1:0]       position,
  output logic [IDX_W-1:0]       value,
  output logic                   last
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_data;
  cmd_t q_head;
  res_t out_res;

  ksw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .random_byte (random_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_data)
  );

  ksw_cmd_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  ksw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // Result fields
  assign kind     = out_res.kind;
  assign position = out_res.position;
  assign value    = out_res.value;
  assign last     = out_res.last;

endmodule
`default_nettype wire
